// ===== hdl/lav_pkg.sv =====
package lav_pkg;

   localparam int COORD_WIDTH = 32;
   // unit vectors are signed Q2.30
   localparam int UNIT_W = 32;
   localparam int FRAC_W = 30;
   // eye is widened to this before the split multiply
   localparam int EYE_EXT_W = 48;
   localparam int EYE_LO_W = 24;

   typedef logic [1:0] row_type;
   localparam row_type ROW_RIGHT = 2'd0;
   localparam row_type ROW_UP = 2'd1;
   localparam row_type ROW_LOOK = 2'd2;

   typedef logic [2:0][UNIT_W-1:0] uvec_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] eye_x;
      logic signed [COORD_WIDTH-1:0] eye_y;
      logic signed [COORD_WIDTH-1:0] eye_z;
      logic signed [COORD_WIDTH-1:0] target_x;
      logic signed [COORD_WIDTH-1:0] target_y;
      logic signed [COORD_WIDTH-1:0] target_z;
      logic signed [COORD_WIDTH-1:0] up_hint_x;
      logic signed [COORD_WIDTH-1:0] up_hint_y;
      logic signed [COORD_WIDTH-1:0] up_hint_z;
   } req_type;

   typedef struct packed {
      row_type row_index;
      logic signed [COORD_WIDTH-1:0] col0;
      logic signed [COORD_WIDTH-1:0] col1;
      logic signed [COORD_WIDTH-1:0] col2;
      logic signed [COORD_WIDTH-1:0] col3;
      logic last_row;
      logic degenerate;
   } rsp_type;

endpackage

// ===== hdl/lav_norm.sv =====
module lav_norm import lav_pkg::*; #(
   parameter int IN_W = 33,
   parameter int SIDE_W = 96
) (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_vld,
   input  logic in_ok,
   input  logic [2:0][IN_W-1:0] in_vec,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_vld,
   output logic out_ok,
   output uvec_type out_vec,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NG = (IN_W + 7) / 8;
   localparam int PAD_W = NG * 8;
   localparam int GW = $clog2(NG);
   localparam int P_W = GW + 3;
   localparam int SQ_N = 31;
   localparam int DV_N = 31;
   localparam int LAT = SQ_N + DV_N + 8;
   localparam int META_W = SIDE_W + 4;

   // meta line: ok, neg[2:0], side
   logic [LAT-1:0] vld_ff;
   logic [META_W-1:0] meta_ff [0:LAT-1];
   logic [META_W-1:0] meta_in;

   logic [2:0][IN_W-1:0] mag1_in;
   logic [2:0] neg1_in;
   logic [PAD_W-1:0] mxp1;
   logic [NG-1:0] gnz1_in;

   logic [2:0][IN_W-1:0] s1_mag_ff, s2_mag_ff, s3_mag_ff;
   logic [NG-1:0] s1_gnz_ff;
   logic [PAD_W-1:0] mxp2;
   logic [GW-1:0] g_sel, s2_g_ff;
   logic [7:0] grp_bits_in, s2_bits_ff;
   logic [2:0] b_sel;
   logic [P_W-1:0] s3_p_ff;
   logic [P_W:0] sh;
   logic [2:0][FRAC_W-1:0] s4_m_in, s4_m_ff, s5_m_ff;
   logic [2:0][2*FRAC_W-1:0] s5_sq_ff;

   logic [61:0] sq_rem_ff [0:SQ_N];
   logic [30:0] sq_root_ff [0:SQ_N];
   logic [2:0][FRAC_W-1:0] sq_m_ff [0:SQ_N];

   logic [2:0][61:0] dv_rem_ff [0:DV_N];
   logic [2:0][30:0] dv_q_ff [0:DV_N];
   logic [30:0] dv_len_ff [0:DV_N];

   uvec_type out_vec_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         neg1_in[l] = in_vec[l][IN_W-1];
         mag1_in[l] = neg1_in[l] ? IN_W'(0) - in_vec[l] : in_vec[l];
      end
      mxp1 = PAD_W'(mag1_in[0] | mag1_in[1] | mag1_in[2]);
      for (int g = 0; g < NG; g++) begin
         gnz1_in[g] = |mxp1[g*8 +: 8];
      end
      meta_in = {in_ok & (|mxp1), neg1_in, in_side};
   end

   // leading one search: group first, then bit within the group
   always_comb begin
      mxp2 = PAD_W'(s1_mag_ff[0] | s1_mag_ff[1] | s1_mag_ff[2]);
      g_sel = '0;
      for (int g = 0; g < NG; g++) begin
         if (s1_gnz_ff[g]) g_sel = GW'(g);
      end
      grp_bits_in = 8'(mxp2 >> {g_sel, 3'b000});
   end

   always_comb begin
      b_sel = '0;
      for (int b = 0; b < 8; b++) begin
         if (s2_bits_ff[b]) b_sel = 3'(b);
      end
   end

   // top bit lands on bit 29
   always_comb begin
      sh = {1'b0, s3_p_ff} + (P_W+1)'(1);
      for (int l = 0; l < 3; l++) begin
         s4_m_in[l] = FRAC_W'({s3_mag_ff[l], {FRAC_W{1'b0}}} >> sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k < LAT; k++) meta_ff[k] <= meta_ff[k-1];
         s1_mag_ff <= mag1_in;
         s1_gnz_ff <= gnz1_in;
         s2_mag_ff <= s1_mag_ff;
         s2_g_ff <= g_sel;
         s2_bits_ff <= grp_bits_in;
         s3_mag_ff <= s2_mag_ff;
         s3_p_ff <= {s2_g_ff, b_sel};
         s4_m_ff <= s4_m_in;
         for (int l = 0; l < 3; l++) begin
            s5_sq_ff[l] <= (2*FRAC_W)'(s4_m_ff[l]) * (2*FRAC_W)'(s4_m_ff[l]);
         end
         s5_m_ff <= s4_m_ff;
         sq_rem_ff[0] <= 62'(s5_sq_ff[0]) + 62'(s5_sq_ff[1]) + 62'(s5_sq_ff[2]);
         sq_root_ff[0] <= '0;
         sq_m_ff[0] <= s5_m_ff;
         for (int l = 0; l < 3; l++) begin
            dv_rem_ff[0][l] <= {2'b00, sq_m_ff[SQ_N][l], {FRAC_W{1'b0}}}
                               + {32'd0, sq_root_ff[SQ_N][30:1]};
         end
         dv_q_ff[0] <= '0;
         dv_len_ff[0] <= sq_root_ff[SQ_N];
         for (int l = 0; l < 3; l++) begin
            out_vec_ff[l] <= meta_ff[LAT-2][SIDE_W+l]
                             ? UNIT_W'(0) - {1'b0, dv_q_ff[DV_N][l]}
                             : {1'b0, dv_q_ff[DV_N][l]};
         end
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
      localparam int I = SQ_N - k;
      logic [63:0] trial;
      logic ge;
      always_comb begin
         trial = ({33'd0, sq_root_ff[k-1]} << (I + 1)) + (64'd1 << (2 * I));
         ge = {2'b00, sq_rem_ff[k-1]} >= trial;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k] <= ge ? sq_rem_ff[k-1] - trial[61:0] : sq_rem_ff[k-1];
            sq_root_ff[k] <= ge ? sq_root_ff[k-1] | (31'd1 << I) : sq_root_ff[k-1];
            sq_m_ff[k] <= sq_m_ff[k-1];
         end
      end
   end

   // restoring divide, three lanes, one quotient bit per stage
   for (genvar k = 1; k <= DV_N; k++) begin : g_div
      localparam int I = DV_N - k;
      logic [61:0] dsh;
      always_comb dsh = {31'd0, dv_len_ff[k-1]} << I;
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_len_ff[k] <= dv_len_ff[k-1];
            for (int l = 0; l < 3; l++) begin
               if (dv_rem_ff[k-1][l] >= dsh) begin
                  dv_rem_ff[k][l] <= dv_rem_ff[k-1][l] - dsh;
                  dv_q_ff[k][l] <= dv_q_ff[k-1][l] | (31'd1 << I);
               end else begin
                  dv_rem_ff[k][l] <= dv_rem_ff[k-1][l];
                  dv_q_ff[k][l] <= dv_q_ff[k-1][l];
               end
            end
         end
      end
   end

   assign out_vld = vld_ff[LAT-1];
   assign out_ok = meta_ff[LAT-1][META_W-1];
   assign out_side = meta_ff[LAT-1][SIDE_W-1:0];
   assign out_vec = out_vec_ff;

endmodule

// ===== hdl/look_at_view_matrix.sv =====
// Look-at camera: builds the 3x4 view matrix from eye, target and up hint.
// Request channel (req_valid/req_ready/req_data) takes one camera per
// transfer, all coordinates signed Q16.16. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns three rows per camera in order:
// right, up, negated look; last_row marks the third. Column 3 is the
// saturated translation. A zero-length look or right vector gives three
// all-zero rows with degenerate set.
// After the first row, the other two rows follow on the next cycles when
// rsp_ready stays high. The datapath is a pipeline of 219 stages (three
// normalizers in series of 70 stages, each a 31-stage square root and a
// 31-stage divider) and takes a camera every cycle while it is not held;
// the row output register sends one row per cycle while rsp_ready is high
// and loads a new camera only as the last row of the previous one is taken.
// While that register cannot load and the last stage is occupied, the whole
// pipeline holds and req_ready drops; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; the block is ready right after.
module look_at_view_matrix import lav_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   localparam int W = COORD_WIDTH;
   localparam int EYE_W = 3 * W;
   localparam int VEC_W = 3 * UNIT_W;
   localparam int ROT_W = (W > 19 ? W : 19) + 1;
   localparam int TR_W = 55;

   logic adv, load;

   // entry stage
   logic e_vld_ff;
   logic [2:0][W:0] e_d_ff, d_in;
   logic [2:0][W-1:0] e_eye_ff, e_up_ff, eye_in, tgt_in, up_in;

   always_comb begin
      eye_in = {req_data.eye_z, req_data.eye_y, req_data.eye_x};
      tgt_in = {req_data.target_z, req_data.target_y, req_data.target_x};
      up_in = {req_data.up_hint_z, req_data.up_hint_y, req_data.up_hint_x};
      for (int j = 0; j < 3; j++) begin
         d_in[j] = {tgt_in[j][W-1], tgt_in[j]} - {eye_in[j][W-1], eye_in[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_d_ff <= d_in;
         e_eye_ff <= eye_in;
         e_up_ff <= up_in;
      end
   end

   // look and up hint normalize side by side
   logic nl_vld, nl_ok, nu_ok;
   uvec_type nl_vec, nu_vec;
   logic [EYE_W-1:0] nl_side;

   lav_norm #(.IN_W(W + 1), .SIDE_W(EYE_W)) u_norm_look (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(e_vld_ff), .in_ok(1'b1), .in_vec(e_d_ff), .in_side(e_eye_ff),
      .out_vld(nl_vld), .out_ok(nl_ok), .out_vec(nl_vec), .out_side(nl_side)
   );

   lav_norm #(.IN_W(W), .SIDE_W(1)) u_norm_hint (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(e_vld_ff), .in_ok(1'b1), .in_vec(e_up_ff), .in_side(1'b0),
      .out_vld(), .out_ok(nu_ok), .out_vec(nu_vec), .out_side()
   );

   // cross products: products stage, then difference stage
   logic x1_vld_ff, x1_ok_ff, x2_vld_ff, x2_ok_ff;
   logic [5:0][63:0] x1_p_ff, x1_p_in;
   uvec_type x1_look_ff, x2_look_ff;
   logic [EYE_W-1:0] x1_eye_ff, x2_eye_ff;
   logic [2:0][62:0] x2_c_ff;

   logic x3_vld_ff, x3_ok_ff, x4_vld_ff, x4_ok_ff;
   logic [5:0][63:0] x3_p_ff, x3_p_in;
   logic [EYE_W+VEC_W-1:0] x3_side_ff, x4_side_ff;
   uvec_type x3_right_ff, x4_right_ff;
   logic [2:0][62:0] x4_c_ff;

   logic nr_vld, nr_ok;
   uvec_type nr_vec;
   logic [EYE_W+VEC_W-1:0] nr_side;
   logic np_vld, np_ok;
   uvec_type np_vec;
   logic [EYE_W+2*VEC_W-1:0] np_side;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         x1_p_in[2*j] = $signed(nl_vec[j == 2 ? 0 : j + 1])
                        * $signed(nu_vec[j == 0 ? 2 : j - 1]);
         x1_p_in[2*j+1] = $signed(nl_vec[j == 0 ? 2 : j - 1])
                          * $signed(nu_vec[j == 2 ? 0 : j + 1]);
         x3_p_in[2*j] = $signed(nr_vec[j == 2 ? 0 : j + 1])
                        * $signed(nr_side[(j == 0 ? 2 : j - 1)*UNIT_W +: UNIT_W]);
         x3_p_in[2*j+1] = $signed(nr_vec[j == 0 ? 2 : j - 1])
                          * $signed(nr_side[(j == 2 ? 0 : j + 1)*UNIT_W +: UNIT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_vld_ff <= 1'b0;
         x2_vld_ff <= 1'b0;
         x3_vld_ff <= 1'b0;
         x4_vld_ff <= 1'b0;
      end else if (adv) begin
         x1_vld_ff <= nl_vld;
         x2_vld_ff <= x1_vld_ff;
         x3_vld_ff <= nr_vld;
         x4_vld_ff <= x3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_p_ff <= x1_p_in;
         x1_ok_ff <= nl_ok & nu_ok;
         x1_look_ff <= nl_vec;
         x1_eye_ff <= nl_side;
         for (int j = 0; j < 3; j++) begin
            x2_c_ff[j] <= 63'(x1_p_ff[2*j] - x1_p_ff[2*j+1]);
            x4_c_ff[j] <= 63'(x3_p_ff[2*j] - x3_p_ff[2*j+1]);
         end
         x2_ok_ff <= x1_ok_ff;
         x2_look_ff <= x1_look_ff;
         x2_eye_ff <= x1_eye_ff;
         x3_p_ff <= x3_p_in;
         x3_ok_ff <= nr_ok;
         x3_side_ff <= nr_side;
         x3_right_ff <= nr_vec;
         x4_ok_ff <= x3_ok_ff;
         x4_side_ff <= x3_side_ff;
         x4_right_ff <= x3_right_ff;
      end
   end

   lav_norm #(.IN_W(63), .SIDE_W(EYE_W + VEC_W)) u_norm_right (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(x2_vld_ff), .in_ok(x2_ok_ff), .in_vec(x2_c_ff),
      .in_side({x2_eye_ff, x2_look_ff}),
      .out_vld(nr_vld), .out_ok(nr_ok), .out_vec(nr_vec), .out_side(nr_side)
   );

   lav_norm #(.IN_W(63), .SIDE_W(EYE_W + 2 * VEC_W)) u_norm_up (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(x4_vld_ff), .in_ok(x4_ok_ff), .in_vec(x4_c_ff),
      .in_side({x4_side_ff, x4_right_ff}),
      .out_vld(np_vld), .out_ok(np_ok), .out_vec(np_vec), .out_side(np_side)
   );

   // output stages: translation products, sums, rounding, saturation
   uvec_type rows_in [0:2];
   logic [2:0][W-1:0] np_eye;
   logic [2:0][EYE_EXT_W-1:0] eye_ext;
   logic signed [55:0] ph_in [0:2][0:2];
   logic signed [56:0] pl_in [0:2][0:2];

   logic o1_vld_ff, o2_vld_ff, o3_vld_ff, o4_vld_ff;
   logic o1_ok_ff, o2_ok_ff, o3_ok_ff, o4_ok_ff;
   uvec_type o1_rows_ff [0:2];
   uvec_type o2_rows_ff [0:2];
   uvec_type o3_rows_ff [0:2];
   logic signed [55:0] o1_ph_ff [0:2][0:2];
   logic signed [56:0] o1_pl_ff [0:2][0:2];
   logic signed [57:0] o2_hi_ff [0:2];
   logic signed [58:0] o2_lo_ff [0:2];
   logic signed [83:0] tot_in [0:2];
   logic signed [53:0] o3_t_ff [0:2];
   logic [2:0][3:0][W-1:0] o4_cols_ff, o4_cols_in;

   function automatic logic [W-1:0] sat_rot(input logic [ROT_W-1:0] x);
      if (x[ROT_W-1:W-1] == {(ROT_W-W+1){x[W-1]}}) return x[W-1:0];
      return {x[ROT_W-1], {(W-1){~x[ROT_W-1]}}};
   endfunction

   function automatic logic [W-1:0] sat_tr(input logic [TR_W-1:0] x);
      if (x[TR_W-1:W-1] == {(TR_W-W+1){x[W-1]}}) return x[W-1:0];
      return {x[TR_W-1], {(W-1){~x[TR_W-1]}}};
   endfunction

   always_comb begin
      np_eye = np_side[EYE_W+2*VEC_W-1:2*VEC_W];
      rows_in[0] = np_side[VEC_W-1:0];
      rows_in[1] = np_vec;
      for (int j = 0; j < 3; j++) begin
         rows_in[2][j] = UNIT_W'(0) - np_side[VEC_W+j*UNIT_W +: UNIT_W];
         eye_ext[j] = EYE_EXT_W'($signed(np_eye[j]));
      end
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            ph_in[r][j] = $signed(rows_in[r][j])
                          * $signed(eye_ext[j][EYE_EXT_W-1:EYE_LO_W]);
            pl_in[r][j] = $signed(rows_in[r][j])
                          * $signed({1'b0, eye_ext[j][EYE_LO_W-1:0]});
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         tot_in[r] = ($signed(84'(o2_hi_ff[r])) <<< EYE_LO_W)
                     + $signed(84'(o2_lo_ff[r])) + (84'sd1 <<< (FRAC_W - 1));
      end
   end

   // Q2.30 to Q16.16 with round half up; translation negated and clamped
   always_comb begin
      logic [32:0] rnd;
      logic [TR_W-1:0] nt;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            rnd = {o3_rows_ff[r][c][UNIT_W-1], o3_rows_ff[r][c]} + 33'd8192;
            o4_cols_in[r][c] = o3_ok_ff ? sat_rot(ROT_W'($signed(rnd[32:14]))) : '0;
         end
         nt = TR_W'(0) - TR_W'(o3_t_ff[r]);
         o4_cols_in[r][3] = o3_ok_ff ? sat_tr(nt) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o1_vld_ff <= 1'b0;
         o2_vld_ff <= 1'b0;
         o3_vld_ff <= 1'b0;
         o4_vld_ff <= 1'b0;
      end else if (adv) begin
         o1_vld_ff <= np_vld;
         o2_vld_ff <= o1_vld_ff;
         o3_vld_ff <= o2_vld_ff;
         o4_vld_ff <= o3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ok_ff <= np_ok;
         o2_ok_ff <= o1_ok_ff;
         o3_ok_ff <= o2_ok_ff;
         o4_ok_ff <= o3_ok_ff;
         o1_rows_ff <= rows_in;
         o2_rows_ff <= o1_rows_ff;
         o3_rows_ff <= o2_rows_ff;
         o1_ph_ff <= ph_in;
         o1_pl_ff <= pl_in;
         for (int r = 0; r < 3; r++) begin
            o2_hi_ff[r] <= 58'(o1_ph_ff[r][0]) + 58'(o1_ph_ff[r][1]) + 58'(o1_ph_ff[r][2]);
            o2_lo_ff[r] <= 59'(o1_pl_ff[r][0]) + 59'(o1_pl_ff[r][1]) + 59'(o1_pl_ff[r][2]);
            o3_t_ff[r] <= tot_in[r][83:30];
         end
         o4_cols_ff <= o4_cols_in;
      end
   end

   // row output register, one row per transfer
   logic s_vld_ff, s_deg_ff;
   row_type s_row_ff;
   logic [2:0][3:0][W-1:0] s_cols_ff;
   logic [3:0][W-1:0] sel_cols;

   assign load = !s_vld_ff || (rsp_ready && s_row_ff == ROW_LOOK);
   assign adv = !o4_vld_ff || load;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
         s_row_ff <= ROW_RIGHT;
      end else if (load) begin
         s_vld_ff <= o4_vld_ff;
         s_row_ff <= ROW_RIGHT;
      end else if (rsp_ready) begin
         s_row_ff <= s_row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s_cols_ff <= o4_cols_ff;
         s_deg_ff <= !o4_ok_ff;
      end
   end

   always_comb begin
      case (s_row_ff)
         ROW_RIGHT: sel_cols = s_cols_ff[0];
         ROW_UP: sel_cols = s_cols_ff[1];
         default: sel_cols = s_cols_ff[2];
      endcase
   end

   assign rsp_valid = s_vld_ff;
   assign rsp_data.row_index = s_row_ff;
   assign rsp_data.col0 = sel_cols[0];
   assign rsp_data.col1 = sel_cols[1];
   assign rsp_data.col2 = sel_cols[2];
   assign rsp_data.col3 = sel_cols[3];
   assign rsp_data.last_row = s_row_ff == ROW_LOOK;
   assign rsp_data.degenerate = s_deg_ff;

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_row |=>
         rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 2'd1)
      else $error("row sequence broken");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.col0 == '0 && rsp_data.col1 == '0 &&
         rsp_data.col2 == '0 && rsp_data.col3 == '0)
      else $error("degenerate row carries data");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_row && !o4_vld_ff |=> !rsp_valid)
      else $error("row output not drained");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear output");

endmodule
